// ===== rtl/core/pip_pkg.sv =====
// shared types and constants of the point-in-polygon test block
package pip_pkg;

	// field widths of the stream words
	localparam int unsigned OP_W     = 1;
	localparam int unsigned INDEX_W  = 6;
	localparam int unsigned FIELD_W  = 32;
	localparam int unsigned COUNT_W  = 7;
	localparam int unsigned IN_DATA_W  = 72;
	localparam int unsigned OUT_DATA_W = 8;

	// bit offsets inside the input tdata
	localparam int unsigned IDX_LO = 0;
	localparam int unsigned X_LO   = IDX_LO + INDEX_W;
	localparam int unsigned Y_LO   = X_LO + FIELD_W;
	localparam int unsigned PAD_LO = Y_LO + FIELD_W;

	// item kinds carried in tuser
	localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
	localparam logic [OP_W-1:0] OP_TEST  = 1'b1;

	// per-edge outcome from the edge unit
	typedef struct packed {
		logic vld;
		logic last;
		logic flip;
	} edge_res_t;

endpackage

// ===== rtl/core/pip_vertex_mem.sv =====
// vertex memory: one write port, one read port, registered read data
module pip_vertex_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/pip_edge_unit.sv =====
// edge unit: straddle check and exact left-of test by split cross products
module pip_edge_unit import pip_pkg::*; #(
	parameter int unsigned COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic                          in_last,
	input  logic signed [COORD_WIDTH-1:0] px,
	input  logic signed [COORD_WIDTH-1:0] py,
	input  logic signed [COORD_WIDTH-1:0] xi,
	input  logic signed [COORD_WIDTH-1:0] yi,
	input  logic signed [COORD_WIDTH-1:0] xj,
	input  logic signed [COORD_WIDTH-1:0] yj,
	output edge_res_t                     res
);

	localparam int unsigned D = COORD_WIDTH + 1;
	localparam int unsigned L = D / 2;
	localparam int unsigned H = D - L;
	localparam int unsigned P = 2 * D;

	// stage 2: differences and straddle
	logic                vld_s2, last_s2;
	logic                cross_s2;
	logic signed [D-1:0] ax_s2, dy_s2, bx_s2, by_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s2  <= in_vld;
			last_s2 <= in_last;
		end
	end

	always_ff @(posedge clk) begin
		ax_s2    <= D'(px) - D'(xi);
		dy_s2    <= D'(yj) - D'(yi);
		bx_s2    <= D'(xj) - D'(xi);
		by_s2    <= D'(py) - D'(yi);
		cross_s2 <= (yi > py) != (yj > py);
	end

	// stage 3: partial products, high halves signed, low halves unsigned
	logic signed [H-1:0] ax_h, dy_h, bx_h, by_h;
	logic        [L-1:0] ax_l, dy_l, bx_l, by_l;

	assign ax_h = ax_s2[D-1:L];
	assign dy_h = dy_s2[D-1:L];
	assign bx_h = bx_s2[D-1:L];
	assign by_h = by_s2[D-1:L];
	assign ax_l = ax_s2[L-1:0];
	assign dy_l = dy_s2[L-1:0];
	assign bx_l = bx_s2[L-1:0];
	assign by_l = by_s2[L-1:0];

	logic                    vld_s3, last_s3;
	logic                    cross_s3, dyneg_s3;
	logic signed [2*H-1:0]   hh1_s3, hh2_s3;
	logic signed [H+L:0]     hl1_s3, lh1_s3, hl2_s3, lh2_s3;
	logic        [2*L-1:0]   ll1_s3, ll2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3  <= 1'b0;
			last_s3 <= 1'b0;
		end else begin
			vld_s3  <= vld_s2;
			last_s3 <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		cross_s3 <= cross_s2;
		dyneg_s3 <= dy_s2[D-1];
		hh1_s3   <= ax_h * dy_h;
		hl1_s3   <= ax_h * $signed({1'b0, dy_l});
		lh1_s3   <= $signed({1'b0, ax_l}) * dy_h;
		ll1_s3   <= ax_l * dy_l;
		hh2_s3   <= bx_h * by_h;
		hl2_s3   <= bx_h * $signed({1'b0, by_l});
		lh2_s3   <= $signed({1'b0, bx_l}) * by_h;
		ll2_s3   <= bx_l * by_l;
	end

	// stage 4: recombine the partials into full products
	logic [P-1:0] sum1, sum2;

	always_comb begin
		sum1 = (P'(hh1_s3) << (2 * L)) + ((P'(hl1_s3) + P'(lh1_s3)) << L) + P'(ll1_s3);
		sum2 = (P'(hh2_s3) << (2 * L)) + ((P'(hl2_s3) + P'(lh2_s3)) << L) + P'(ll2_s3);
	end

	logic                vld_s4, last_s4;
	logic                cross_s4, dyneg_s4;
	logic signed [P-1:0] p1_s4, p2_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4  <= 1'b0;
			last_s4 <= 1'b0;
		end else begin
			vld_s4  <= vld_s3;
			last_s4 <= last_s3;
		end
	end

	always_ff @(posedge clk) begin
		cross_s4 <= cross_s3;
		dyneg_s4 <= dyneg_s3;
		p1_s4    <= $signed(sum1);
		p2_s4    <= $signed(sum2);
	end

	// point is left of the edge when the product order matches the sign of dy
	always_comb begin
		res.vld  = vld_s4;
		res.last = last_s4;
		res.flip = cross_s4 & (dyneg_s4 ? (p1_s4 > p2_s4) : (p1_s4 < p2_s4));
	end

endmodule

// ===== rtl/core/point_in_polygon_test.sv =====
// top level of the even-odd point-in-polygon test
//
//  channel  signals                     word
//  ------   --------------------------  ----------------------------------------
//  s_       s_tvalid s_tready s_tdata   tdata: vertex_index[5:0] coord_x[37:6]
//           s_tuser                     coord_y[69:38]; tuser: op
//  m_       m_tvalid m_tready m_tdata   tdata: is_inside[0]
//  cfg_     cfg_valid cfg_ready         cfg_data: vertex_count[6:0]
//
// a test reads the vertex memory's single read port once per edge, n+1 reads
// for n vertices, then drains the edge unit's arithmetic pipeline; the block
// takes no new word until the test result is in the output register.
// reset clears control and vertex_count; vertex memory contents are not reset.
// a finished result waits in the output register while new words are taken;
// a test result that finds the output register full holds until it drains.
module point_in_polygon_test import pip_pkg::*; #(
	parameter int unsigned MAX_VERTICES = 64,
	parameter int unsigned COORD_WIDTH  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // vertex_index, coord_x, coord_y, zero pad
	input  logic [OP_W-1:0]       s_tuser,  // op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // is_inside, zero pad
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [COUNT_W-1:0]    cfg_data
);

	localparam int unsigned AW    = $clog2(MAX_VERTICES);
	localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int unsigned CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	localparam int unsigned CW    = COORD_WIDTH;
	localparam int unsigned NSLOT = 1 << INDEX_W;
	localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_VERTICES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_HOLD = 2'd3;

	// field unpacking
	logic signed [CW-1:0] in_x, in_y;
	logic [INDEX_W-1:0]   in_idx;

	assign in_idx = s_tdata[IDX_LO +: INDEX_W];

	generate
		if (CW <= FIELD_W) begin : g_narrow
			assign in_x = s_tdata[X_LO +: CW];
			assign in_y = s_tdata[Y_LO +: CW];
		end else begin : g_wide
			assign in_x = {{(CW - FIELD_W){s_tdata[X_LO + FIELD_W - 1]}}, s_tdata[X_LO +: FIELD_W]};
			assign in_y = {{(CW - FIELD_W){s_tdata[Y_LO + FIELD_W - 1]}}, s_tdata[Y_LO +: FIELD_W]};
		end
	endgenerate

	// write index wraps onto the memory depth
	logic [AW-1:0] slot_lut [0:NSLOT-1];

	generate
		for (genvar g = 0; g < NSLOT; g++) begin : g_slot
			assign slot_lut[g] = AW'(g % MAX_VERTICES);
		end
	endgenerate

	// config register
	logic [COUNT_W-1:0] count_q;
	logic [CMP_W-1:0]   count_ext;
	logic [CNT_W-1:0]   n_eff;

	assign cfg_ready = 1'b1;
	assign count_ext = CMP_W'(count_q);
	assign n_eff     = (count_ext > MAX_C) ? CNT_W'(MAX_VERTICES) : CNT_W'(count_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	// sequencer
	logic [1:0]           state_q;
	logic [CNT_W-1:0]     n_q, step_q;
	logic signed [CW-1:0] px_q, py_q;
	logic                 parity_q, done_q;
	logic                 out_vld_q, out_bit_q;
	logic                 in_acc, is_test;
	logic                 rd_en;
	logic [CNT_W-1:0]     addr_full;
	logic [AW-1:0]        rd_addr;
	logic                 rd_vld_s1, edge_vld_s1, edge_last_s1;
	logic [2*CW-1:0]      rd_data;
	logic [2*CW-1:0]      prev_q;
	logic                 out_free;
	edge_res_t            res;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign is_test  = (s_tuser == OP_TEST);
	assign out_free = !out_vld_q || m_tready;

	// first read fetches the closing vertex n-1, then vertices 0..n-1
	assign rd_en     = (state_q == ST_RUN);
	assign addr_full = (step_q == '0) ? n_q - 1'b1 : step_q - 1'b1;
	assign rd_addr   = addr_full[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			n_q          <= '0;
			step_q       <= '0;
			parity_q     <= 1'b0;
			done_q       <= 1'b0;
			out_vld_q    <= 1'b0;
			rd_vld_s1    <= 1'b0;
			edge_vld_s1  <= 1'b0;
			edge_last_s1 <= 1'b0;
		end else begin
			rd_vld_s1    <= rd_en;
			edge_vld_s1  <= rd_en && (step_q != '0);
			edge_last_s1 <= rd_en && (step_q == n_q);

			if ((state_q == ST_HOLD) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end

			if (res.vld) begin
				parity_q <= parity_q ^ res.flip;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc && is_test) begin
						n_q      <= n_eff;
						step_q   <= '0;
						parity_q <= 1'b0;
						done_q   <= 1'b0;
						// an empty polygon answers outside at once
						state_q  <= (n_eff == '0) ? ST_HOLD : ST_RUN;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == n_q) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (res.vld && res.last) begin
						done_q  <= parity_q ^ res.flip;
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && is_test) begin
			px_q <= in_x;
			py_q <= in_y;
		end
		if ((state_q == ST_HOLD) && out_free) begin
			out_bit_q <= done_q;
		end
		if (rd_vld_s1) begin
			prev_q <= rd_data;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(OUT_DATA_W - 1){1'b0}}, out_bit_q};

	pip_vertex_mem #(
		.DEPTH (MAX_VERTICES),
		.WIDTH (2 * CW)
	) u_mem (
		.clk     (clk),
		.wr_en   (in_acc && (s_tuser == OP_WRITE)),
		.wr_addr (slot_lut[in_idx]),
		.wr_data ({in_x, in_y}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// current read is vertex i, the one before it is vertex j
	pip_edge_unit #(
		.COORD_WIDTH (CW)
	) u_edge (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (edge_vld_s1),
		.in_last (edge_last_s1),
		.px      (px_q),
		.py      (py_q),
		.xi      ($signed(rd_data[2*CW-1:CW])),
		.yi      ($signed(rd_data[CW-1:0])),
		.xj      ($signed(prev_q[2*CW-1:CW])),
		.yj      ($signed(prev_q[CW-1:0])),
		.res     (res)
	);

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the even-odd point-in-polygon test block
`timescale 1ns / 100ps

module tb_top;
	import pip_pkg::*;

	localparam int unsigned NUM_SLOTS   = 64;
	localparam int unsigned SETTLE_CYC  = 80;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned ITEM_GOAL   = 850;

	localparam logic [31:0] C_MIN = 32'h8000_0000;
	localparam logic [31:0] C_MAX = 32'h7fff_ffff;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [INDEX_W-1:0] idx;
		logic [31:0]        x;
		logic [31:0]        y;
	} stream_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [OP_W-1:0] s_tuser = OP_WRITE;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [COUNT_W-1:0] cfg_data = '0;

	point_in_polygon_test #(
		.MAX_VERTICES(NUM_SLOTS),
		.COORD_WIDTH(32)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic signed [31:0] poly_x [NUM_SLOTS];
	logic signed [31:0] poly_y [NUM_SLOTS];
	logic [COUNT_W-1:0] model_count = '0;

	stream_word_t pending_words [$];
	logic         expected_inside [$];

	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned item_total = 0;
	int unsigned tests_checked = 0;
	int unsigned inside_seen = 0;
	int unsigned vertex_writes = 0;
	int unsigned count_settings = 0;

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatch_count++;
	endtask

	// exact even-odd crossing count, no division
	function automatic logic predict_inside(input logic signed [31:0] px, py);
		int n, i, j;
		logic parity;
		logic signed [127:0] xi, yi, xj, yj, pxw, pyw, dy, lhs, rhs;
		n = (model_count > NUM_SLOTS) ? NUM_SLOTS : int'(model_count);
		parity = 1'b0;
		pxw = 128'(px);
		pyw = 128'(py);
		for (i = 0; i < n; i++) begin
			j = (i == 0) ? n - 1 : i - 1;
			xi = 128'(poly_x[INDEX_W'(i)]);
			yi = 128'(poly_y[INDEX_W'(i)]);
			xj = 128'(poly_x[INDEX_W'(j)]);
			yj = 128'(poly_y[INDEX_W'(j)]);
			if ((yi > pyw) != (yj > pyw)) begin
				dy = yj - yi;
				lhs = (pxw - xi) * dy;
				rhs = (xj - xi) * (pyw - yi);
				if ((dy > 0 && lhs < rhs) || (dy < 0 && lhs > rhs))
					parity = ~parity;
			end
		end
		return parity;
	endfunction

	// sender: bursts of words with random gaps
	stream_word_t cur_word;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (cur_word.op == OP_WRITE) begin
					poly_x[cur_word.idx] = cur_word.x;
					poly_y[cur_word.idx] = cur_word.y;
					vertex_writes++;
				end else begin
					expected_inside = {expected_inside,
						predict_inside(cur_word.x, cur_word.y)};
				end
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					cur_word = pending_words.pop_front();
					s_tdata <= {2'b00, cur_word.y, cur_word.x, cur_word.idx};
					s_tuser <= cur_word.op;
					s_tvalid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 15);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: back-pressure in one of four stall styles, picked at random
	int unsigned stall_mode = 0;
	int unsigned stall_left = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILURE");
			$finish;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_inside.size() == 0) begin
					report_mismatch("result word with no test pending");
				end else begin
					logic want;
					want = expected_inside.pop_front();
					tests_checked++;
					if (want)
						inside_seen++;
					if (m_tdata[0] !== want)
						report_mismatch($sformatf("is_inside got %b want %b",
							m_tdata[0], want));
				end
			end
			if (cycle_count % 256 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (cycle_count % 7) < 3;
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						m_tready <= 1'b0;
					end else begin
						if ($urandom_range(0, 15) == 0)
							stall_left = $urandom_range(1, 30);
						m_tready <= 1'b1;
					end
				end
			endcase
		end
	end

	// stimulus side copy of the vertex slots, used to aim test points
	logic [31:0] plan_x [NUM_SLOTS];
	logic [31:0] plan_y [NUM_SLOTS];

	task automatic queue_word(input logic [OP_W-1:0] op, input int unsigned idx,
			input logic [31:0] x, input logic [31:0] y);
		stream_word_t w;
		w.op = op;
		w.idx = idx[INDEX_W-1:0];
		w.x = x;
		w.y = y;
		if (op == OP_WRITE) begin
			plan_x[INDEX_W'(idx)] = x;
			plan_y[INDEX_W'(idx)] = y;
		end
		pending_words = {pending_words, w};
		item_total++;
	endtask

	task automatic wait_idle();
		while (pending_words.size() > 0 || s_tvalid || expected_inside.size() > 0)
			@(posedge clk);
		// trailing vertex writes cause no result
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_vertex_count(input logic [COUNT_W-1:0] value);
		wait_idle();
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		model_count = value;
		count_settings++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_coord(input int unsigned mode);
		logic [31:0] v;
		case (mode)
			0: v = $urandom;
			3: begin
				case ($urandom_range(0, 6))
					0: v = C_MIN;
					1: v = C_MAX;
					2: v = 32'h0;
					3: v = 32'hffff_ffff;
					4: v = 32'h1;
					5: v = C_MIN + 1;
					default: v = C_MAX - 1;
				endcase
			end
			default: v = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
		endcase
		return v;
	endfunction

	initial begin
		int unsigned n_used, n_tests, k, r, mode, large_phases;
		logic [COUNT_W-1:0] cnt;
		logic [31:0] px, py;

		large_phases = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty polygon over the full-range square corners
		set_vertex_count(7'd0);
		queue_word(OP_WRITE, 0, C_MIN, C_MIN);
		queue_word(OP_WRITE, 1, C_MAX, C_MIN);
		queue_word(OP_WRITE, 2, C_MAX, C_MAX);
		queue_word(OP_WRITE, 3, C_MIN, C_MAX);
		queue_word(OP_WRITE, 63, C_MAX, C_MIN);
		queue_word(OP_TEST, 0, 32'h0, 32'h0);

		set_vertex_count(7'd4);
		queue_word(OP_TEST, 63, 32'h0, 32'h0);
		queue_word(OP_TEST, 0, C_MIN, C_MIN);
		queue_word(OP_TEST, 0, C_MAX, C_MAX);
		queue_word(OP_TEST, 0, C_MIN, 32'h0);
		queue_word(OP_TEST, 0, C_MAX, 32'h0);
		queue_word(OP_TEST, 0, 32'h0, C_MIN);
		queue_word(OP_TEST, 0, 32'h0, C_MAX);
		queue_word(OP_TEST, 0, 32'hffff_ffff, 32'hffff_ffff);

		// one or two vertices never give an inside result
		set_vertex_count(7'd1);
		queue_word(OP_TEST, 0, 32'h0, 32'h0);
		set_vertex_count(7'd2);
		queue_word(OP_TEST, 0, 32'h0, 32'h0);

		// triangle below the diagonal
		set_vertex_count(7'd3);
		queue_word(OP_TEST, 0, 32'h1, 32'h0);
		queue_word(OP_TEST, 0, 32'h0, 32'h1);
		queue_word(OP_TEST, 0, C_MAX - 1, C_MIN + 1);

		while (item_total < ITEM_GOAL) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				cnt = 7'd0;
			else if (r == 1)
				cnt = 7'd1;
			else if (r == 2)
				cnt = 7'd2;
			else if (r == 3 && large_phases < 3) begin
				cnt = 7'd64;
				large_phases++;
			end else if (r == 4 && large_phases < 5) begin
				cnt = ($urandom_range(0, 1) == 0) ? 7'd127 : 7'($urandom_range(65, 126));
				large_phases++;
			end else if (r == 5)
				cnt = 7'($urandom_range(13, 30));
			else
				cnt = 7'($urandom_range(3, 12));
			set_vertex_count(cnt);
			n_used = (cnt > NUM_SLOTS) ? NUM_SLOTS : 32'(cnt);
			mode = $urandom_range(0, 3);

			// fresh polygon in the slots in use
			for (k = 0; k < n_used; k++)
				queue_word(OP_WRITE, k, pick_coord(mode), pick_coord(mode));
			if (n_used == 0)
				queue_word(OP_WRITE, $urandom_range(0, 63), $urandom, $urandom);

			n_tests = $urandom_range(8, 20);
			for (k = 0; k < n_tests; k++) begin
				r = $urandom_range(0, 9);
				if (r == 7 && n_used > 0) begin
					queue_word(OP_WRITE, $urandom_range(0, n_used - 1),
						pick_coord(mode), pick_coord(mode));
				end else if (r == 8) begin
					queue_word(OP_WRITE, $urandom_range(0, 63), $urandom, $urandom);
				end else begin
					if (n_used > 0 && $urandom_range(0, 2) == 0) begin
						// aim at a vertex height or column to hit the strict compare
						px = plan_x[INDEX_W'($urandom_range(0, n_used - 1))]
							+ $urandom_range(0, 2) - 1;
						py = plan_y[INDEX_W'($urandom_range(0, n_used - 1))];
						if ($urandom_range(0, 1) == 0)
							px = pick_coord(mode);
					end else begin
						px = pick_coord(($urandom_range(0, 3) == 0) ? 0 : mode);
						py = pick_coord(($urandom_range(0, 3) == 0) ? 0 : mode);
					end
					queue_word(OP_TEST, $urandom_range(0, 63), px, py);
				end
			end
		end

		wait_idle();
		if (expected_inside.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_inside.size()));
		$display("ran %0d words: %0d vertex writes, %0d point tests (%0d inside)",
			item_total, vertex_writes, tests_checked, inside_seen);
		$display("vertex_count written %0d times, %0d mismatches", count_settings,
			mismatch_count);
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/pip_pkg.sv
rtl/core/pip_vertex_mem.sv
rtl/core/pip_edge_unit.sv
rtl/core/point_in_polygon_test.sv
bench/tb_top.sv
